@@ src/cclb_pkg.sv @@
package cclb_pkg;

  // lexical modes
  localparam logic [2:0] MODE_CODE   = 3'd0;
  localparam logic [2:0] MODE_LINE   = 3'd1;
  localparam logic [2:0] MODE_BLOCK  = 3'd2;
  localparam logic [2:0] MODE_STRING = 3'd3;
  localparam logic [2:0] MODE_CHAR   = 3'd4;

  // character codes
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;

  // per-item write request from the lexer into the result queue
  typedef struct packed {
    logic push0;  // first result present
    logic push1;  // second result present (only with push0)
    logic last;   // last result of this item closes the text
  } push_t;

endpackage

@@ src/cclb_lexer.sv @@
module cclb_lexer #(
  parameter int unsigned CHAR_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [CHAR_WIDTH-1:0] char_i,
  input  logic                  eot_i,
  output logic [CHAR_WIDTH-1:0] char0_o,
  output logic [CHAR_WIDTH-1:0] char1_o,
  output cclb_pkg::push_t       push_o
);

  localparam logic [CHAR_WIDTH-1:0] NL     = CHAR_WIDTH'(cclb_pkg::CH_NL);
  localparam logic [CHAR_WIDTH-1:0] STAR   = CHAR_WIDTH'(cclb_pkg::CH_STAR);
  localparam logic [CHAR_WIDTH-1:0] SLASH  = CHAR_WIDTH'(cclb_pkg::CH_SLASH);
  localparam logic [CHAR_WIDTH-1:0] DQUOTE = CHAR_WIDTH'(cclb_pkg::CH_DQUOTE);
  localparam logic [CHAR_WIDTH-1:0] SQUOTE = CHAR_WIDTH'(cclb_pkg::CH_SQUOTE);
  localparam logic [CHAR_WIDTH-1:0] BSLASH = CHAR_WIDTH'(cclb_pkg::CH_BSLASH);
  localparam logic [CHAR_WIDTH-1:0] SPACE  = CHAR_WIDTH'(cclb_pkg::CH_SPACE);

  logic [2:0] mode_q, mode_d;
  logic       slash_q, slash_d;
  logic       star_q, star_d;
  logic       esc_q, esc_d;

  logic                  opens;   // held slash plus slash or star
  logic                  pre;     // held slash goes out first
  logic                  main_v;
  logic [CHAR_WIDTH-1:0] main_c;
  logic                  tail_v;
  logic [CHAR_WIDTH-1:0] tail_c;
  logic                  eot_slash;

  always_comb begin
    mode_d = mode_q;
    slash_d = 1'b0;
    star_d = star_q;
    esc_d = esc_q;
    main_v = 1'b0;
    main_c = SPACE;
    opens = slash_q && (char_i == SLASH || char_i == STAR);
    pre = slash_q && !opens;

    if (opens) begin
      mode_d = (char_i == SLASH) ? cclb_pkg::MODE_LINE : cclb_pkg::MODE_BLOCK;
      star_d = 1'b0;
    end else begin
      case (mode_q)
        cclb_pkg::MODE_LINE: begin
          main_v = 1'b1;
          if (char_i == NL) begin
            main_c = char_i;
            mode_d = cclb_pkg::MODE_CODE;
          end
        end
        cclb_pkg::MODE_BLOCK: begin
          main_v = 1'b1;
          if (star_q && char_i == SLASH) begin
            mode_d = cclb_pkg::MODE_CODE;
            star_d = 1'b0;
          end else begin
            star_d = (char_i == STAR);
          end
        end
        cclb_pkg::MODE_STRING, cclb_pkg::MODE_CHAR: begin
          main_v = 1'b1;
          if (esc_q) begin
            esc_d = 1'b0;
          end else if (char_i == BSLASH) begin
            esc_d = 1'b1;
          end else if (char_i == ((mode_q == cclb_pkg::MODE_STRING) ? DQUOTE : SQUOTE)) begin
            mode_d = cclb_pkg::MODE_CODE;
          end
        end
        default: begin
          mode_d = cclb_pkg::MODE_CODE;
          if (char_i == SLASH) begin
            slash_d = 1'b1;
          end else if (char_i == DQUOTE) begin
            main_v = 1'b1;
            mode_d = cclb_pkg::MODE_STRING;
            esc_d = 1'b0;
          end else if (char_i == SQUOTE) begin
            main_v = 1'b1;
            mode_d = cclb_pkg::MODE_CHAR;
            esc_d = 1'b0;
          end else begin
            main_v = 1'b1;
            main_c = char_i;
          end
        end
      endcase
    end

    // a slash still held at end of text goes out as is
    eot_slash = eot_i && slash_d;
    tail_v = main_v || eot_slash;
    tail_c = main_v ? main_c : SLASH;

    if (opens) begin
      char0_o = SPACE;
      char1_o = SPACE;
      push_o.push0 = 1'b1;
      push_o.push1 = 1'b1;
    end else begin
      char0_o = pre ? SLASH : tail_c;
      char1_o = tail_c;
      push_o.push0 = pre || tail_v;
      push_o.push1 = pre && tail_v;
    end
    push_o.last = eot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= cclb_pkg::MODE_CODE;
      slash_q <= 1'b0;
      star_q <= 1'b0;
      esc_q <= 1'b0;
    end else if (advance_i) begin
      if (eot_i) begin
        mode_q <= cclb_pkg::MODE_CODE;
        slash_q <= 1'b0;
        star_q <= 1'b0;
        esc_q <= 1'b0;
      end else begin
        mode_q <= mode_d;
        slash_q <= slash_d;
        star_q <= star_d;
        esc_q <= esc_d;
      end
    end
  end

endmodule

@@ src/cclb_out_fifo.sv @@
module cclb_out_fifo #(
  parameter int unsigned CHAR_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cclb_pkg::push_t       push_i,
  input  logic [CHAR_WIDTH-1:0] char0_i,
  input  logic [CHAR_WIDTH-1:0] char1_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [CHAR_WIDTH-1:0] char_o,
  output logic                  last_o
);

  localparam int unsigned Depth = cclb_pkg::FIFO_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [CHAR_WIDTH-1:0] char_mem [Depth];
  logic                  last_mem [Depth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  pop;
  logic                  last0, last1;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= CntW'(Depth - 2));
  assign char_o  = char_mem[rd_q];
  assign last_o  = last_mem[rd_q];

  // the end-of-text mark sits on whichever result comes last
  assign last0 = push_i.last && !push_i.push1;
  assign last1 = push_i.last;

  always_comb begin
    wr_d = wr_q + PtrW'(push_i.push0) + PtrW'(push_i.push1);
    rd_d = rd_q + PtrW'(pop);
    count_d = count_q + CntW'(push_i.push0) + CntW'(push_i.push1) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      char_mem[wr_q] <= char0_i;
      last_mem[wr_q] <= last0;
    end
    if (push_i.push1) begin
      char_mem[wr_q + PtrW'(1)] <= char1_i;
      last_mem[wr_q + PtrW'(1)] <= last1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      count_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      count_q <= count_d;
    end
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue count beyond depth");

  a_push_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push1 |-> push_i.push0)
    else $error("second result pushed without first");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push0 |-> count_q <= CntW'(Depth - 2))
    else $error("push into queue without room for two");

endmodule

@@ src/c_comment_literal_blanker_top.sv @@
// channel  | dir | tdata (low bit up)         | tlast
// s_axis   | in  | char_in, zero pad to bytes | end_of_text
// m_axis   | out | char_out, zero pad         | final_out
//
// one character is taken per cycle while the queue has room; it is lexed
// while it sits in the input register, and its 0 to 2 results go into a
// four-entry result queue that drains one per cycle on m_axis while ready.
// with m_axis ready, sustained rate is one character per cycle while items
// give at most one; two-result items are bounded by the single output port.
// rst_ni clears lexer state and queue pointers; no clearing pass.
// a stalled m_axis fills the queue past two entries, then s_axis_tready drops.
module c_comment_literal_blanker_top #(
  parameter int unsigned CHAR_WIDTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((CHAR_WIDTH + 7) / 8)*8-1:0] s_axis_tdata,   // char_in
  input  logic                                s_axis_tlast,   // end_of_text
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((CHAR_WIDTH + 7) / 8)*8-1:0] m_axis_tdata,   // char_out
  output logic                                m_axis_tlast    // final_out
);

  localparam int unsigned DataW = ((CHAR_WIDTH + 7) / 8) * 8;

  logic                  in_valid_q;
  logic [CHAR_WIDTH-1:0] in_char_q;
  logic                  in_last_q;
  logic                  advance;
  logic                  room;
  logic [CHAR_WIDTH-1:0] char0, char1, out_char;
  cclb_pkg::push_t       push, push_gated;

  assign advance       = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata[CHAR_WIDTH-1:0];
      in_last_q <= s_axis_tlast;
    end
  end

  cclb_lexer #(
    .CHAR_WIDTH(CHAR_WIDTH)
  ) u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .char_i   (in_char_q),
    .eot_i    (in_last_q),
    .char0_o  (char0),
    .char1_o  (char1),
    .push_o   (push)
  );

  always_comb begin
    push_gated = push;
    push_gated.push0 = push.push0 && advance;
    push_gated.push1 = push.push1 && advance;
  end

  cclb_out_fifo #(
    .CHAR_WIDTH(CHAR_WIDTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_gated),
    .char0_i(char0),
    .char1_i(char1),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .char_o (out_char),
    .last_o (m_axis_tlast)
  );

  assign m_axis_tdata = DataW'(out_char);

endmodule
